>>> rtl/hlsp_pkg.sv
// Package for the hop-limited shortest path core: field widths and codes.
// No dependencies.
`timescale 1ns / 1ps
package hlsp_pkg;
  localparam int unsigned DistW = 32;
  localparam int unsigned LenW  = 24;
  localparam int unsigned LinkW = 8;
  localparam int unsigned HopW  = 4;
  localparam int unsigned NodeW = 5;
  localparam int unsigned SlotW = 3;
  localparam logic [HopW-1:0] HopMax = '1;
  localparam logic [DistW-1:0] DistMax = '1;
  localparam logic FuncWrite = 1'b0;
  localparam logic FuncRun   = 1'b1;
  localparam logic CfgNodeCount = 1'b0;
  localparam logic CfgHopLimit  = 1'b1;
  typedef struct packed {
    logic             used;
    logic [LinkW-1:0] link;
    logic [NodeW-1:0] far;
    logic [LenW-1:0]  len;
  } slot_t;
endpackage

>>> rtl/hlsp_ram.sv
// Generic single-port write, single read-port RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
module hlsp_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

>>> rtl/hop_limited_shortest_path_core.sv
// Top level of the hop-limited shortest path core.
// Depends on hlsp_pkg and hlsp_ram.
// A write transaction stores one adjacency slot. A run transaction clears the per-node
// labels one node at a time and then seeds the root. Each pop then steps through pop,
// stack read, label read and label capture. Each slot scanned steps through adjacency
// read, label read, and compare and write back; a slot whose far node is out of range,
// or the unused slot that ends a list, skips the compare. A node with a full list of
// MAX_DEGREE slots takes one more slot check to finish, and the empty stack is seen at pop.
// One result per active node follows, each with its own label read, held while out_tready
// is low. Input and configuration are refused for the whole run. The stack, adjacency
// and label memories each have one read port, which sets this sequence of steps. The
// number of pops depends on the graph and the hop limit.
`timescale 1ns / 1ps
module hop_limited_shortest_path_core
  import hlsp_pkg::*;
#(
  parameter int unsigned NODES       = 32,
  parameter int unsigned MAX_DEGREE  = 8,
  parameter int unsigned STACK_DEPTH = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // func, node, slot, slot_used, link_id, far_node, length, zero pad
  input  logic [47:0] in_tdata,
  input  logic        out_tready,
  output logic        out_tvalid,
  // node_index, distance, reached, pred_link, hop_count, stack_overflow, zero pad
  output logic [55:0] out_tdata,
  output logic        out_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [5:0]  cfg_data
);
  localparam int unsigned NW  = $clog2(NODES);
  localparam int unsigned DW  = (MAX_DEGREE > 1) ? $clog2(MAX_DEGREE) : 1;
  localparam int unsigned AW  = $clog2(NODES * MAX_DEGREE);
  localparam int unsigned SW  = $clog2(STACK_DEPTH);
  localparam int unsigned LW  = 1 + DistW + HopW;
  localparam int unsigned CW  = $clog2(NODES + 1);

  localparam logic [3:0] S_IDLE = 4'd0, S_CLR = 4'd1, S_POP = 4'd2, S_POPW = 4'd3,
                         S_SLOT = 4'd4, S_ADJ = 4'd5, S_CMP = 4'd6, S_OUTR = 4'd7,
                         S_SEED = 4'd8, S_OUT = 4'd9, S_CURW = 4'd10, S_CUR = 4'd11;

  logic [3:0] st_r, st_nxt;
  logic [5:0] node_count_r;
  logic [3:0] hop_limit_r;
  logic [CW-1:0] n_act;
  logic [NW:0] idx_r;
  logic [SW:0] sp_r;
  logic ovf_r;
  logic [NW-1:0] cur_r, nx_r;
  logic [NodeW-1:0] f_node_r;
  logic [DW:0] k_r;
  logic [DistW-1:0] cur_d_r;
  logic [HopW-1:0] cur_h_r;
  logic [LinkW-1:0] link_r;
  logic [DistW-1:0] sum_r;

  logic f_func, f_used;
  logic [NodeW-1:0] f_node, f_far;
  logic [SlotW-1:0] f_slot;
  logic [LinkW-1:0] f_link;
  logic [LenW-1:0] f_len;
  assign f_func = in_tdata[0];
  assign f_node = in_tdata[5:1];
  assign f_slot = in_tdata[8:6];
  assign f_used = in_tdata[9];
  assign f_link = in_tdata[17:10];
  assign f_far  = in_tdata[22:18];
  assign f_len  = in_tdata[46:23];

  assign n_act = (32'(node_count_r) > NODES) ? CW'(NODES) : CW'(node_count_r);
  assign cfg_ready = (st_r == S_IDLE);
  assign in_tready = (st_r == S_IDLE);

  // memories
  logic adj_we; logic [AW-1:0] adj_wa, adj_ra; slot_t adj_wd, adj_rd;
  logic lab_we; logic [NW-1:0] lab_wa, lab_ra; logic [LW-1:0] lab_wd, lab_rd;
  logic prd_we; logic [NW-1:0] prd_wa; logic [LinkW-1:0] prd_wd, prd_rd;
  logic stk_we; logic [SW-1:0] stk_wa, stk_ra; logic [NW-1:0] stk_wd, stk_rd;

  hlsp_ram #(.WIDTH($bits(slot_t)), .DEPTH(NODES*MAX_DEGREE)) u_adj (
    .clk, .we(adj_we), .waddr(adj_wa), .wdata(adj_wd), .raddr(adj_ra), .rdata(adj_rd));
  hlsp_ram #(.WIDTH(LW), .DEPTH(NODES)) u_lab (
    .clk, .we(lab_we), .waddr(lab_wa), .wdata(lab_wd), .raddr(lab_ra), .rdata(lab_rd));
  hlsp_ram #(.WIDTH(LinkW), .DEPTH(NODES)) u_prd (
    .clk, .we(prd_we), .waddr(prd_wa), .wdata(prd_wd), .raddr(lab_ra), .rdata(prd_rd));
  hlsp_ram #(.WIDTH(NW), .DEPTH(STACK_DEPTH)) u_stk (
    .clk, .we(stk_we), .waddr(stk_wa), .wdata(stk_wd), .raddr(stk_ra), .rdata(stk_rd));

  logic in_acc;
  assign in_acc = in_tvalid && in_tready;

  logic lab_v; logic [DistW-1:0] lab_d; logic [HopW-1:0] lab_h;
  assign lab_v = lab_rd[LW-1];
  assign lab_d = lab_rd[HopW +: DistW];
  assign lab_h = lab_rd[HopW-1:0];

  logic [DistW:0] sum_w;
  assign sum_w = {1'b0, cur_d_r} + {{(DistW+1-LenW){1'b0}}, adj_rd.len};
  logic [HopW:0] h_inc;
  logic [HopW-1:0] h_new;
  assign h_inc = {1'b0, cur_h_r} + 1'b1;
  assign h_new = h_inc[HopW] ? HopMax : h_inc[HopW-1:0];
  logic better;
  assign better = !lab_v || (lab_d > sum_r);
  logic far_ok;
  assign far_ok = (32'(adj_rd.far) < 32'(n_act)) && (32'(adj_rd.far) < NODES);
  logic root_ok;
  assign root_ok = (32'(f_node_r) < 32'(n_act));

  always_comb begin
    st_nxt = st_r;
    adj_we = 1'b0;
    adj_wa = AW'(({{(32-NodeW){1'b0}}, f_node} * MAX_DEGREE) + 32'(f_slot));
    adj_wd = '{used: f_used, link: f_link, far: f_far, len: f_len};
    adj_ra = AW'((32'(cur_r) * MAX_DEGREE) + 32'(k_r));
    lab_we = 1'b0; lab_wa = nx_r; lab_wd = {1'b1, sum_r, h_new}; lab_ra = nx_r;
    prd_we = 1'b0; prd_wa = nx_r; prd_wd = link_r;
    stk_we = 1'b0; stk_wa = sp_r[SW-1:0]; stk_wd = nx_r;
    stk_ra = SW'(sp_r - 1'b1);
    unique case (st_r)
      S_IDLE: begin
        if (in_acc) begin
          if (f_func == FuncWrite) begin
            adj_we = (32'(f_node) < NODES) && (32'(f_slot) < MAX_DEGREE);
          end else if (n_act != '0) begin
            st_nxt = S_CLR;
          end
        end
      end
      S_CLR: begin
        lab_we = 1'b1; lab_wa = idx_r[NW-1:0]; lab_wd = '0;
        if (idx_r == (NW+1)'(NODES - 1)) st_nxt = S_SEED;
      end
      S_SEED: begin
        // root: distance 0, hop 0, own number as predecessor, first stack entry
        lab_wa = NW'(f_node_r); lab_wd = {1'b1, {DistW{1'b0}}, {HopW{1'b0}}};
        prd_wa = NW'(f_node_r); prd_wd = LinkW'(f_node_r);
        stk_wa = '0; stk_wd = NW'(f_node_r);
        lab_we = root_ok; prd_we = root_ok; stk_we = root_ok;
        st_nxt = S_POP;
      end
      S_POP: st_nxt = (sp_r == '0) ? S_OUTR : S_POPW;
      S_POPW: st_nxt = S_CURW;
      S_CURW: begin lab_ra = cur_r; st_nxt = S_CUR; end
      S_CUR: st_nxt = S_SLOT;
      S_SLOT: st_nxt = (k_r == (DW+1)'(MAX_DEGREE)) ? S_POP : S_ADJ;
      S_ADJ: begin
        lab_ra = NW'(adj_rd.far);
        if (!adj_rd.used) st_nxt = S_POP;
        else if (!far_ok) st_nxt = S_SLOT;
        else st_nxt = S_CMP;
      end
      S_CMP: begin
        if (better) begin
          lab_we = 1'b1; prd_we = 1'b1;
          if (h_new < hop_limit_r && sp_r < (SW+1)'(STACK_DEPTH)) stk_we = 1'b1;
        end
        st_nxt = S_SLOT;
      end
      S_OUTR: begin lab_ra = idx_r[NW-1:0]; st_nxt = S_OUT; end
      S_OUT: begin
        lab_ra = idx_r[NW-1:0];
        if (out_tready) st_nxt = out_tlast ? S_IDLE : S_OUTR;
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE; node_count_r <= 6'd32; hop_limit_r <= 4'd6;
      sp_r <= '0; ovf_r <= 1'b0; idx_r <= '0;
    end else begin
      st_r <= st_nxt;
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CfgNodeCount) node_count_r <= cfg_data;
        else hop_limit_r <= cfg_data[3:0];
      end
      unique case (st_r)
        S_IDLE: begin
          idx_r <= '0; ovf_r <= 1'b0; sp_r <= '0;
          f_node_r <= f_node;
        end
        S_CLR: begin
          if (idx_r == (NW+1)'(NODES - 1)) idx_r <= '0;
          else idx_r <= idx_r + 1'b1;
        end
        S_SEED: if (root_ok) sp_r <= (SW+1)'(1);
        S_POP: if (sp_r != '0) sp_r <= sp_r - 1'b1;
        S_POPW: ;
        S_CURW: ;
        S_CUR: begin
          cur_d_r <= lab_d; cur_h_r <= lab_h; k_r <= '0;
        end
        S_SLOT: ;
        S_ADJ: begin
          nx_r <= NW'(adj_rd.far); link_r <= adj_rd.link;
          sum_r <= sum_w[DistW] ? DistMax : sum_w[DistW-1:0];
          k_r <= k_r + 1'b1;
        end
        S_CMP: begin
          if (better && h_new < hop_limit_r) begin
            if (sp_r < (SW+1)'(STACK_DEPTH)) sp_r <= sp_r + 1'b1;
            else ovf_r <= 1'b1;
          end
        end
        S_OUTR: ;
        S_OUT: if (out_tready) idx_r <= idx_r + 1'b1;
        default: ;
      endcase
      if (st_r == S_POPW) cur_r <= stk_rd;
    end
  end

  logic [DistW-1:0] o_dist; logic [LinkW-1:0] o_pred; logic [HopW-1:0] o_hop;
  assign o_dist = lab_v ? lab_d : '0;
  assign o_pred = lab_v ? prd_rd : '0;
  assign o_hop  = lab_v ? lab_h : '0;
  assign out_tvalid = (st_r == S_OUT);
  assign out_tlast  = (idx_r == (NW+1)'(n_act - 1'b1));
  assign out_tdata = {5'd0, ovf_r, o_hop, o_pred, lab_v, o_dist, NodeW'(idx_r)};

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast));
  a_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !out_tvalid);
  a_sp_range: assert property (@(posedge clk) disable iff (!rst_n)
    sp_r <= (SW+1)'(STACK_DEPTH));
  a_out_idx: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (32'(idx_r) < 32'(n_act)));
endmodule

>>> sim/tb_hop_limited_shortest_path_core.sv
// Testbench for hop_limited_shortest_path_core: random and directed adjacency loads and
// searches, checked against a built-in label-correcting predictor. Depends on hlsp_pkg
// and the core RTL.
`timescale 1ns / 1ps
module tb_hop_limited_shortest_path_core;
  import hlsp_pkg::*;

  localparam int NumNodes      = 32;
  localparam int Degree        = 8;
  localparam int StackDepth    = 256;
  localparam int SettleCycles  = 12000;
  localparam int WatchdogLimit = 200000;

  typedef struct {
    logic             func;
    logic [NodeW-1:0] node;
    logic [SlotW-1:0] slot;
    logic             used;
    logic [LinkW-1:0] link;
    logic [NodeW-1:0] far;
    logic [LenW-1:0]  len;
  } item_t;

  typedef struct {
    logic [NodeW-1:0] idx;
    logic [DistW-1:0] distance;
    logic             reached;
    logic [LinkW-1:0] pred;
    logic [HopW-1:0]  hops;
    logic             ovf;
    logic             last;
  } label_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [47:0] in_tdata = '0;
  logic        out_tready = 1'b0;
  logic        out_tvalid;
  logic [55:0] out_tdata;
  logic        out_tlast;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_index = 1'b0;
  logic [5:0]  cfg_data = '0;

  hop_limited_shortest_path_core dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tready(out_tready), .out_tvalid(out_tvalid), .out_tdata(out_tdata),
    .out_tlast(out_tlast),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  // predictor state
  slot_t            adj_m[NumNodes*Degree];
  logic [DistW-1:0] dist_m[NumNodes];
  bit               reach_m[NumNodes];
  logic [LinkW-1:0] pred_m[NumNodes];
  int               hop_m[NumNodes];
  int               stack_m[StackDepth];
  int               node_count_m = 32;
  int               hop_limit_m = 6;

  // slots already queued for writing; a used slot below the last always has a written successor
  bit               slot_written[NumNodes*Degree];

  item_t  pending_items[$];
  label_t expected_labels[$];
  item_t  in_item;
  bit     in_taken = 0, out_taken = 0;
  bit     in_burst = 0, out_burst = 0;
  int     in_gap = 0, out_stall = 0;
  int     idle_cycles = 0;
  int     errors = 0;

  function automatic void search_labels(item_t it);
    int n, sp, cur, nx, h;
    logic [DistW:0] sum;
    logic [DistW-1:0] d;
    bit ovf;
    slot_t s;
    label_t lb;
    if (it.func == FuncWrite) begin
      adj_m[it.node*Degree+it.slot] = '{it.used, it.link, it.far, it.len};
      return;
    end
    n = node_count_m > NumNodes ? NumNodes : node_count_m;
    if (n == 0) return;
    for (int i = 0; i < NumNodes; i++) begin
      reach_m[i] = 0;
      dist_m[i] = '0;
      hop_m[i] = 0;
    end
    sp = 0;
    ovf = 0;
    if (it.node < n) begin
      reach_m[it.node] = 1;
      pred_m[it.node] = LinkW'(it.node);
      stack_m[0] = it.node;
      sp = 1;
    end
    while (sp > 0) begin
      sp--;
      cur = stack_m[sp];
      for (int k = 0; k < Degree; k++) begin
        s = adj_m[cur*Degree+k];
        if (!s.used) break;
        nx = s.far;
        if (nx >= n) continue;
        sum = {1'b0, dist_m[cur]} + s.len;
        d = sum[DistW] ? DistMax : sum[DistW-1:0];
        if (!reach_m[nx] || dist_m[nx] > d) begin
          h = hop_m[cur] + 1;
          reach_m[nx] = 1;
          dist_m[nx] = d;
          pred_m[nx] = s.link;
          hop_m[nx] = h > 15 ? 15 : h;
          if (hop_m[nx] < hop_limit_m) begin
            if (sp < StackDepth) begin
              stack_m[sp] = nx;
              sp++;
            end else begin
              ovf = 1;
            end
          end
        end
      end
    end
    for (int i = 0; i < n; i++) begin
      lb.idx = NodeW'(i);
      lb.reached = reach_m[i];
      lb.distance = reach_m[i] ? dist_m[i] : '0;
      lb.pred = reach_m[i] ? pred_m[i] : '0;
      lb.hops = reach_m[i] ? HopW'(hop_m[i]) : '0;
      lb.ovf = ovf;
      lb.last = (i == n - 1);
      expected_labels = {expected_labels, lb};
    end
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("%0t: mismatch on %s: got %0h, expected %0h", $time, what, got, want);
    errors++;
  endtask

  task automatic check_label();
    label_t e;
    if (expected_labels.size() == 0) begin
      report_mismatch("unexpected result", out_tdata, 0);
      return;
    end
    e = expected_labels.pop_front();
    if (out_tdata[4:0] !== e.idx) report_mismatch("node_index", out_tdata[4:0], e.idx);
    if (out_tdata[36:5] !== e.distance)
      report_mismatch("distance", out_tdata[36:5], e.distance);
    if (out_tdata[37] !== e.reached) report_mismatch("reached", out_tdata[37], e.reached);
    if (out_tdata[45:38] !== e.pred) report_mismatch("pred_link", out_tdata[45:38], e.pred);
    if (out_tdata[49:46] !== e.hops) report_mismatch("hop_count", out_tdata[49:46], e.hops);
    if (out_tdata[50] !== e.ovf) report_mismatch("stack_overflow", out_tdata[50], e.ovf);
    if (out_tlast !== e.last) report_mismatch("tlast", out_tlast, e.last);
  endtask

  // monitor and watchdog
  always @(posedge clk) begin
    in_taken <= rst_n && in_tvalid && in_tready;
    out_taken <= rst_n && out_tvalid && out_tready;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CfgNodeCount) node_count_m = cfg_data;
        else hop_limit_m = cfg_data[3:0];
      end
      if (in_tvalid && in_tready) search_labels(in_item);
      if (out_tvalid && out_tready) check_label();
      if ((cfg_valid && cfg_ready) || (in_tvalid && in_tready) || (out_tvalid && out_tready))
        idle_cycles <= 0;
      else if (idle_cycles + 1 >= WatchdogLimit) begin
        $display("Simulation FAILED");
        $finish;
      end else
        idle_cycles <= idle_cycles + 1;
    end
  end

  // input driver
  always @(negedge clk) begin
    item_t it;
    if (rst_n && (!in_tvalid || in_taken)) begin
      if (in_gap > 0) begin
        in_gap <= in_gap - 1;
        in_tvalid <= 1'b0;
      end else if (pending_items.size() > 0) begin
        it = pending_items.pop_front();
        in_item <= it;
        in_tdata <= {1'b0, it.len, it.far, it.link, it.used, it.slot, it.node, it.func};
        in_tvalid <= 1'b1;
        in_gap <= in_burst ? 0 : $urandom_range(0, 5);
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // result sink
  always @(negedge clk) begin
    int stall;
    if (rst_n) begin
      stall = (out_tready && out_taken) ? (out_burst ? 0 : $urandom_range(0, 5)) : out_stall;
      if (stall > 0) begin
        out_tready <= 1'b0;
        out_stall <= stall - 1;
      end else begin
        out_tready <= 1'b1;
        out_stall <= 0;
      end
    end
  end

  task automatic put_slot(int node, int slot, bit used, int link, int far, int len);
    item_t it;
    it = '{FuncWrite, NodeW'(node), SlotW'(slot), used, LinkW'(link), NodeW'(far), LenW'(len)};
    pending_items = {pending_items, it};
    slot_written[node*Degree+slot] = 1'b1;
    if (used && slot < Degree - 1 && !slot_written[node*Degree+slot+1])
      put_slot(node, slot + 1, 0, 0, 0, 0);
  endtask

  task automatic put_run(int root);
    item_t it;
    it = '{FuncRun, NodeW'(root), SlotW'($urandom), 1'($urandom), LinkW'($urandom),
           NodeW'($urandom), LenW'($urandom)};
    pending_items = {pending_items, it};
  endtask

  task automatic write_reg(logic idx, logic [5:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    while (pending_items.size() != 0 || in_tvalid || expected_labels.size() != 0)
      @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
    in_burst = $urandom_range(0, 2) == 0;
    out_burst = $urandom_range(0, 2) == 0;
  endtask

  task automatic random_traffic(int count);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 5) == 0)
        put_run($urandom_range(0, 31));
      else
        put_slot($urandom_range(0, 31), $urandom_range(0, 7), $urandom_range(0, 4) != 0,
                 $urandom_range(0, 255), $urandom_range(0, 31),
                 $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 4095));
    end
    put_run($urandom_range(0, 31));
  endtask

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // every list starts out empty
    for (int i = 0; i < NumNodes; i++)
      put_slot(i, 0, 0, $urandom, $urandom, $urandom);

    put_slot(0, 2, 1, 12, 31, 5);
    put_slot(0, 1, 1, 11, 2, 'hFFFFFF);
    put_slot(0, 0, 1, 10, 1, 'h000100);
    put_slot(1, 0, 1, 255, 2, 1);
    put_slot(2, 0, 1, 0, 0, 0);
    put_run(0);
    put_run(2);
    put_run(31);
    drain();

    write_reg(CfgNodeCount, 6'd0);
    write_reg(CfgHopLimit, 6'h30);
    put_run(0);
    drain();

    write_reg(CfgNodeCount, 6'd1);
    write_reg(CfgHopLimit, 6'h3F);
    put_run(0);
    put_run(5);
    drain();

    write_reg(CfgNodeCount, 6'd3);
    write_reg(CfgHopLimit, 6'd1);
    put_run(0);
    put_run(4);
    drain();

    // chain where every slot re-improves the next node, piling copies onto the stack
    write_reg(CfgNodeCount, 6'd63);
    write_reg(CfgHopLimit, 6'd15);
    for (int i = 0; i < 4; i++)
      for (int k = Degree - 1; k >= 0; k--)
        put_slot(i, k, 1, i * Degree + k, i + 1, Degree - k);
    put_slot(4, 0, 0, 0, 0, 0);
    put_run(0);
    put_run(3);
    drain();

    for (int p = 0; p < 3; p++) begin
      write_reg(CfgNodeCount, p == 2 ? 6'd32 : 6'($urandom_range(2, 32)));
      write_reg(CfgHopLimit, p == 2 ? 6'd15 : 6'($urandom_range(1, 15)));
      random_traffic(16);
      drain();
    end

    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
